### sv/dedq_pkg.sv
`timescale 1ns / 1ps

package dedq_pkg;

  localparam int DEFAULT_DEPTH = 64;
  localparam int WORD_W        = 64;
  localparam int POS_W         = 16;
  localparam int TYPE_W        = 3;

  // request codes as they arrive on the input channel
  localparam logic [TYPE_W-1:0] REQ_PUSH_BACK  = 3'd0;
  localparam logic [TYPE_W-1:0] REQ_PUSH_FRONT = 3'd1;
  localparam logic [TYPE_W-1:0] REQ_POP_BACK   = 3'd2;
  localparam logic [TYPE_W-1:0] REQ_POP_FRONT  = 3'd3;
  localparam logic [TYPE_W-1:0] REQ_READ       = 3'd4;
  localparam logic [TYPE_W-1:0] REQ_WRITE      = 3'd5;
  localparam logic [TYPE_W-1:0] REQ_CLEAR      = 3'd6;

  // classified operation handed from front end to back end
  typedef enum logic [2:0] {
    OP_PUSH_BACK,
    OP_PUSH_FRONT,
    OP_POP_BACK,
    OP_POP_FRONT,
    OP_READ,
    OP_WRITE,
    OP_CLEAR,
    OP_NOP
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef struct packed {
    op_t               op;
    logic [WORD_W-1:0] data;
    logic [POS_W-1:0]  pos;
  } cmd_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_ACCESS,
    S_FETCH,
    S_DONE
  } back_state_t;

endpackage

### sv/dedq_req_if.sv
`timescale 1ns / 1ps

interface dedq_req_if;
  logic                          valid;
  logic                          ready;
  logic [dedq_pkg::TYPE_W-1:0]   req_type;
  logic [dedq_pkg::WORD_W-1:0]   data_word;
  logic [dedq_pkg::POS_W-1:0]    position;

  modport source (output valid, output req_type, output data_word, output position,
                  input ready);
  modport sink   (input valid, input req_type, input data_word, input position,
                  output ready);
endinterface

### sv/dedq_rsp_if.sv
`timescale 1ns / 1ps

interface dedq_rsp_if #(
  parameter int CNT_W = $clog2(dedq_pkg::DEFAULT_DEPTH + 1)
);
  logic                          valid;
  logic                          ready;
  logic [dedq_pkg::WORD_W-1:0]   read_word;
  logic [CNT_W-1:0]              occupancy;
  logic                          is_empty;
  logic [1:0]                    status;

  modport source (output valid, output read_word, output occupancy, output is_empty,
                  output status, input ready);
  modport sink   (input valid, input read_word, input occupancy, input is_empty,
                  input status, output ready);
endinterface

### sv/bounded_double_ended_queue_core.sv
`timescale 1ns / 1ps
// bounded double-ended queue of 64-bit words in a ring buffer of DEPTH entries
// - req channel (valid/ready): one request word per handshake carrying req_type,
//   data_word and position; push/pop at either end, indexed read/write, clear
// - rsp channel (valid/ready): exactly one result word per request, in order,
//   with read_word, occupancy, is_empty and status
// - a two-deep command queue in the front end keeps taking request words while
//   the back end works or while a result word waits in the output register
// - pushes, pops, clear, unused codes and indexed access on an empty queue:
//   the back end goes from S_IDLE to S_DONE, which loads the output register
// - indexed access on a non-empty queue: the position is reduced modulo the
//   count by a bit-serial remainder unit, 16 steps; a write passes S_DIV,
//   S_ACCESS and S_DONE in the back end, a read also S_FETCH for the registered
//   read of the entry memory
// - one request is carried out at a time; the back end takes no new command until the last result word is loaded
// - reset (synchronous, active high) empties the queue and the command queue;
//   the entry memory is not cleared, only entries inside the count are read
// - when rsp.ready is low the result word holds in the output register; the
//   back end then waits, and once the command queue fills req.ready drops
module bounded_double_ended_queue_core #(
  parameter int DEPTH = dedq_pkg::DEFAULT_DEPTH
) (
  input logic        clk,
  input logic        rst,
  dedq_req_if.sink   req,
  dedq_rsp_if.source rsp
);

  // front to back command handoff
  logic           cmd_valid;
  logic           cmd_ready;
  dedq_pkg::cmd_t cmd;

  // front end: accepts request words and classifies the code
  dedq_front u_front (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd)
  );

  // back end: queue state, entry memory, remainder unit and output register
  dedq_back #(
    .DEPTH (DEPTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .rsp       (rsp)
  );

endmodule

### sv/dedq_ram.sv
`timescale 1ns / 1ps

module dedq_ram #(
  parameter int WIDTH = dedq_pkg::WORD_W,
  parameter int DEPTH = dedq_pkg::DEFAULT_DEPTH
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### sv/dedq_front.sv
`timescale 1ns / 1ps

module dedq_front (
  input  logic               clk,
  input  logic               rst,
  dedq_req_if.sink           req,
  output logic               cmd_valid,
  input  logic               cmd_ready,
  output dedq_pkg::cmd_t     cmd
);

  localparam logic [1:0] Q_FULL = 2'd2;

  dedq_pkg::cmd_t slots [2];
  dedq_pkg::cmd_t in_cmd;
  logic           wr_ptr;
  logic           rd_ptr;
  logic [1:0]     fill;
  logic           push;
  logic           pop;

  // classify the raw request code
  always_comb begin
    in_cmd.data = req.data_word;
    in_cmd.pos  = req.position;
    case (req.req_type)
      dedq_pkg::REQ_PUSH_BACK:  in_cmd.op = dedq_pkg::OP_PUSH_BACK;
      dedq_pkg::REQ_PUSH_FRONT: in_cmd.op = dedq_pkg::OP_PUSH_FRONT;
      dedq_pkg::REQ_POP_BACK:   in_cmd.op = dedq_pkg::OP_POP_BACK;
      dedq_pkg::REQ_POP_FRONT:  in_cmd.op = dedq_pkg::OP_POP_FRONT;
      dedq_pkg::REQ_READ:       in_cmd.op = dedq_pkg::OP_READ;
      dedq_pkg::REQ_WRITE:      in_cmd.op = dedq_pkg::OP_WRITE;
      dedq_pkg::REQ_CLEAR:      in_cmd.op = dedq_pkg::OP_CLEAR;
      default:                  in_cmd.op = dedq_pkg::OP_NOP;
    endcase
  end

  assign req.ready = (fill != Q_FULL);
  assign push      = req.valid && req.ready;
  assign pop       = cmd_valid && cmd_ready;
  assign cmd_valid = (fill != 2'd0);
  assign cmd       = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        fill <= fill + 2'd1;
      end else if (pop && !push) begin
        fill <= fill - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= in_cmd;
    end
  end

endmodule

### sv/dedq_div.sv
`timescale 1ns / 1ps

module dedq_div #(
  parameter int DIV_W = $clog2(dedq_pkg::DEFAULT_DEPTH + 1)
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [dedq_pkg::POS_W-1:0] dividend,
  input  logic [DIV_W-1:0]           divisor,
  output logic                       done,
  output logic [DIV_W-1:0]           rem
);

  localparam int POS_W = dedq_pkg::POS_W;
  localparam int CNT_W = $clog2(POS_W);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [POS_W-1:0] shf;
  logic [DIV_W-1:0] rem_acc;
  logic [DIV_W-1:0] divisor_q;
  logic [DIV_W:0]   trial;
  logic [DIV_W-1:0] rem_next;

  // restoring remainder, one dividend bit per cycle
  always_comb begin
    trial = {rem_acc, shf[POS_W-1]};
    if (trial >= {1'b0, divisor_q}) begin
      rem_next = DIV_W'(trial - {1'b0, divisor_q});
    end else begin
      rem_next = trial[DIV_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(POS_W - 1);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      shf       <= dividend;
      rem_acc   <= '0;
      divisor_q <= divisor;
    end else if (busy) begin
      shf     <= {shf[POS_W-2:0], 1'b0};
      rem_acc <= rem_next;
    end
  end

  assign rem = rem_acc;

endmodule

### sv/dedq_back.sv
`timescale 1ns / 1ps

module dedq_back #(
  parameter int DEPTH = dedq_pkg::DEFAULT_DEPTH
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           cmd_valid,
  output logic           cmd_ready,
  input  dedq_pkg::cmd_t cmd,
  dedq_rsp_if.source     rsp
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);
  localparam logic [PW:0]   DEPTH_EXT  = (PW + 1)'(DEPTH);
  localparam logic [PW-1:0] LAST_SLOT  = PW'(DEPTH - 1);

  dedq_pkg::back_state_t state, state_next;
  logic [CW-1:0]               count, count_next;
  logic [PW-1:0]               front, front_next;
  dedq_pkg::op_t               op, op_next;
  logic [dedq_pkg::WORD_W-1:0] data, data_next;
  logic [dedq_pkg::WORD_W-1:0] res_word, res_word_next;
  dedq_pkg::status_t           res_status, res_status_next;

  logic                        out_valid;
  logic [dedq_pkg::WORD_W-1:0] out_word;
  logic [CW-1:0]               out_count;
  dedq_pkg::status_t           out_status;
  logic                        load_out;

  logic                        ram_we;
  logic [PW-1:0]               ram_waddr;
  logic [dedq_pkg::WORD_W-1:0] ram_wdata;
  logic [PW-1:0]               ram_raddr;
  logic [dedq_pkg::WORD_W-1:0] ram_rdata;

  logic                        div_start;
  logic                        div_done;
  logic [CW-1:0]               div_rem;
  logic [PW-1:0]               slot_idx;
  logic                        full;
  logic                        empty;
  logic [dedq_pkg::POS_W-1:0]  data_pos_q;

  function automatic logic [PW-1:0] wrap_add(logic [PW-1:0] a, logic [PW-1:0] b);
    logic [PW:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    if (sum >= DEPTH_EXT) begin
      sum = sum - DEPTH_EXT;
    end
    return sum[PW-1:0];
  endfunction

  assign full       = (count == FULL_COUNT);
  assign empty      = (count == '0);
  assign slot_idx   = wrap_add(front, div_rem[PW-1:0]);
  assign data_pos_q = cmd.pos;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dedq_pkg::S_IDLE;
      count <= '0;
      front <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
      front <= front_next;
    end
  end

  always_ff @(posedge clk) begin
    op         <= op_next;
    data       <= data_next;
    res_word   <= res_word_next;
    res_status <= res_status_next;
  end

  always_comb begin
    state_next      = state;
    count_next      = count;
    front_next      = front;
    op_next         = op;
    data_next       = data;
    res_word_next   = res_word;
    res_status_next = res_status;
    cmd_ready       = 1'b0;
    load_out        = 1'b0;
    ram_we          = 1'b0;
    ram_waddr       = front;
    ram_wdata       = data;
    ram_raddr       = slot_idx;
    div_start       = 1'b0;

    case (state)
      dedq_pkg::S_IDLE: begin
        cmd_ready = 1'b1;
        if (cmd_valid) begin
          op_next         = cmd.op;
          data_next       = cmd.data;
          res_word_next   = '0;
          res_status_next = dedq_pkg::ST_OK;
          state_next      = dedq_pkg::S_DONE;
          case (cmd.op)
            dedq_pkg::OP_PUSH_BACK: begin
              if (full) begin
                res_status_next = dedq_pkg::ST_FULL;
              end else begin
                ram_we     = 1'b1;
                ram_waddr  = wrap_add(front, count[PW-1:0]);
                ram_wdata  = cmd.data;
                count_next = count + 1'b1;
              end
            end
            dedq_pkg::OP_PUSH_FRONT: begin
              if (full) begin
                res_status_next = dedq_pkg::ST_FULL;
              end else begin
                front_next = (front == '0) ? LAST_SLOT : front - 1'b1;
                ram_we     = 1'b1;
                ram_waddr  = front_next;
                ram_wdata  = cmd.data;
                count_next = count + 1'b1;
              end
            end
            dedq_pkg::OP_POP_BACK: begin
              if (empty) begin
                res_status_next = dedq_pkg::ST_EMPTY;
              end else begin
                count_next = count - 1'b1;
              end
            end
            dedq_pkg::OP_POP_FRONT: begin
              if (empty) begin
                res_status_next = dedq_pkg::ST_EMPTY;
              end else begin
                front_next = wrap_add(front, PW'(1));
                count_next = count - 1'b1;
              end
            end
            dedq_pkg::OP_READ, dedq_pkg::OP_WRITE: begin
              if (empty) begin
                // empty queue: the new zero element is the target at index zero
                ram_we     = 1'b1;
                ram_waddr  = front;
                ram_wdata  = (cmd.op == dedq_pkg::OP_WRITE) ? cmd.data : '0;
                count_next = CW'(1);
              end else begin
                div_start  = 1'b1;
                state_next = dedq_pkg::S_DIV;
              end
            end
            dedq_pkg::OP_CLEAR: begin
              count_next = '0;
              front_next = '0;
            end
            default: begin
            end
          endcase
        end
      end
      dedq_pkg::S_DIV: begin
        if (div_done) begin
          state_next = dedq_pkg::S_ACCESS;
        end
      end
      dedq_pkg::S_ACCESS: begin
        if (op inside {dedq_pkg::OP_WRITE}) begin
          ram_we     = 1'b1;
          ram_waddr  = slot_idx;
          ram_wdata  = data;
          state_next = dedq_pkg::S_DONE;
        end else begin
          state_next = dedq_pkg::S_FETCH;
        end
      end
      dedq_pkg::S_FETCH: begin
        res_word_next = ram_rdata;
        state_next    = dedq_pkg::S_DONE;
      end
      dedq_pkg::S_DONE: begin
        if (!out_valid || rsp.ready) begin
          load_out   = 1'b1;
          state_next = dedq_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = dedq_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_word   <= res_word;
      out_count  <= count;
      out_status <= res_status;
    end
  end

  assign rsp.valid     = out_valid;
  assign rsp.read_word = out_word;
  assign rsp.occupancy = out_count;
  assign rsp.is_empty  = (out_count == '0);
  assign rsp.status    = out_status;

  dedq_ram #(
    .WIDTH (dedq_pkg::WORD_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  dedq_div #(
    .DIV_W (CW)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (data_pos_q),
    .divisor  (count),
    .done     (div_done),
    .rem      (div_rem)
  );

  a_push_counts: assert property (@(posedge clk) disable iff (rst)
    (state == dedq_pkg::S_IDLE && cmd_valid && cmd.op == dedq_pkg::OP_PUSH_BACK && !full)
    |=> count == CW'($past(count) + 1'b1))
    else $error("push back did not grow the count");

  a_no_late_write: assert property (@(posedge clk) disable iff (rst)
    (state == dedq_pkg::S_FETCH || state == dedq_pkg::S_DONE) |-> !ram_we)
    else $error("store written outside an access step");

  a_div_owned: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == dedq_pkg::S_DIV)
    else $error("remainder finished while back end not waiting");

  a_full_status: assert property (@(posedge clk) disable iff (rst)
    (state == dedq_pkg::S_DONE && res_status == dedq_pkg::ST_FULL) |-> full)
    else $error("push dropped while queue not full");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    (state == dedq_pkg::S_DIV) |-> (count != '0 && count <= FULL_COUNT))
    else $error("index reduction started with a bad count");

endmodule

### tb/dedq_checker.sv
`timescale 1ns / 1ps

module dedq_checker #(
  parameter int DEPTH = dedq_pkg::DEFAULT_DEPTH
) (
  input  logic clk,
  input  logic rst,
  dedq_req_if  req,
  dedq_rsp_if  rsp,
  output int   err_count,
  output int   outstanding,
  output int   full_hits,
  output int   empty_hits,
  output int   peak_fill
);

  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int WORD_W = dedq_pkg::WORD_W;
  localparam int TYPE_W = dedq_pkg::TYPE_W;
  localparam int POS_W  = dedq_pkg::POS_W;

  typedef struct {
    logic [WORD_W-1:0] word;
    logic [CNT_W-1:0]  occ;
    logic              empty;
    dedq_pkg::status_t st;
  } answer_t;

  // shadow copy of the ring buffer
  logic [WORD_W-1:0] ring[DEPTH];
  int                head;
  int                held;

  answer_t due_answers[$];
  int      errs;
  int      n_full;
  int      n_empty;
  int      peak;
  int      n_rsp;

  function automatic answer_t apply_request(logic [TYPE_W-1:0] kind,
                                            logic [WORD_W-1:0] word,
                                            logic [POS_W-1:0] pos);
    answer_t res;
    int      slot;
    res.word = '0;
    res.st   = dedq_pkg::ST_OK;
    case (kind)
      dedq_pkg::REQ_PUSH_BACK: begin
        if (held >= DEPTH) begin
          res.st = dedq_pkg::ST_FULL;
        end else begin
          ring[(head + held) % DEPTH] = word;
          held++;
        end
      end
      dedq_pkg::REQ_PUSH_FRONT: begin
        if (held >= DEPTH) begin
          res.st = dedq_pkg::ST_FULL;
        end else begin
          head = (head + DEPTH - 1) % DEPTH;
          ring[head] = word;
          held++;
        end
      end
      dedq_pkg::REQ_POP_BACK: begin
        if (held == 0) res.st = dedq_pkg::ST_EMPTY;
        else held--;
      end
      dedq_pkg::REQ_POP_FRONT: begin
        if (held == 0) begin
          res.st = dedq_pkg::ST_EMPTY;
        end else begin
          head = (head + 1) % DEPTH;
          held--;
        end
      end
      dedq_pkg::REQ_READ, dedq_pkg::REQ_WRITE: begin
        // access on an empty queue inserts a zero entry first
        if (held == 0) begin
          ring[head] = '0;
          held = 1;
        end
        slot = (head + int'(pos) % held) % DEPTH;
        if (kind == dedq_pkg::REQ_READ) res.word = ring[slot];
        else ring[slot] = word;
      end
      dedq_pkg::REQ_CLEAR: begin
        held = 0;
        head = 0;
      end
      default: ;
    endcase
    res.occ   = held[CNT_W-1:0];
    res.empty = (held == 0);
    return res;
  endfunction

  always @(posedge clk) begin
    answer_t want;
    answer_t got;
    if (rst) begin
      head = 0;
      held = 0;
      for (int i = 0; i < DEPTH; i++) ring[i] = '0;
      due_answers.delete();
      errs    = 0;
      n_full  = 0;
      n_empty = 0;
      peak    = 0;
      n_rsp   = 0;
    end else begin
      // results leave before this edge's request is counted
      if (rsp.valid && rsp.ready) begin
        n_rsp++;
        if (due_answers.size() == 0) begin
          errs++;
          if (errs <= 10)
            $display("unexpected result word %0d: word=%h occ=%0d empty=%0b status=%0d",
                     n_rsp, rsp.read_word, rsp.occupancy, rsp.is_empty, rsp.status);
        end else begin
          want = due_answers[0];
          due_answers.delete(0);
          got.word  = rsp.read_word;
          got.occ   = rsp.occupancy;
          got.empty = rsp.is_empty;
          got.st    = dedq_pkg::status_t'(rsp.status);
          if (got.word !== want.word || got.occ !== want.occ ||
              got.empty !== want.empty || got.st !== want.st) begin
            errs++;
            if (errs <= 10)
              $display({"mismatch on result %0d: exp word=%h occ=%0d empty=%0b st=%0d,",
                        " got word=%h occ=%0d empty=%0b st=%0d"},
                       n_rsp, want.word, want.occ, want.empty, want.st,
                       got.word, got.occ, got.empty, got.st);
          end
        end
      end
      if (req.valid && req.ready) begin
        want = apply_request(req.req_type, req.data_word, req.position);
        if (want.st == dedq_pkg::ST_FULL) n_full++;
        if (want.st == dedq_pkg::ST_EMPTY) n_empty++;
        if (held > peak) peak = held;
        due_answers = {due_answers, want};
      end
    end
    err_count   <= errs;
    outstanding <= due_answers.size();
    full_hits   <= n_full;
    empty_hits  <= n_empty;
    peak_fill   <= peak;
  end

endmodule

### tb/tb.sv
`timescale 1ns / 1ps

// stimulus and verdict for the bounded double-ended queue core
// - a short directed run hits empty pops, access on an empty queue, the
//   unused request code, clear and the index extremes
// - then phases of random requests biased toward filling, draining or a mix,
//   so the queue reaches both full and empty many times
// - the checker beside the block predicts every result word and compares
module tb;

  localparam int DEPTH        = dedq_pkg::DEFAULT_DEPTH;
  localparam int CNT_W        = $clog2(DEPTH + 1);
  localparam int WORD_W       = dedq_pkg::WORD_W;
  localparam int TYPE_W       = dedq_pkg::TYPE_W;
  localparam int POS_W        = dedq_pkg::POS_W;
  localparam int PHASES       = 10;
  localparam int PHASE_ITEMS  = 125;
  localparam int LONG_HOLD    = 300;
  localparam int WATCHDOG     = 2000;
  localparam int DRAIN_CYCLES = 40;

  // request code with no operation behind it
  localparam logic [TYPE_W-1:0] REQ_UNUSED = 3'd7;

  // phase biases
  localparam int MODE_FILL  = 0;
  localparam int MODE_DRAIN = 1;
  localparam int MODE_MIX   = 2;

  logic clk;
  logic rst;

  dedq_req_if                      req ();
  dedq_rsp_if #(.CNT_W(CNT_W))     rsp ();

  int errors;
  int pending;
  int full_hits;
  int empty_hits;
  int peak_fill;
  int sent;

  bit tx_gaps;
  bit rx_gaps;
  bit hold_long;
  bit hold_done;

  bounded_double_ended_queue_core #(.DEPTH(DEPTH)) uut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  dedq_checker #(.DEPTH(DEPTH)) chk (
    .clk         (clk),
    .rst         (rst),
    .req         (req),
    .rsp         (rsp),
    .err_count   (errors),
    .outstanding (pending),
    .full_hits   (full_hits),
    .empty_hits  (empty_hits),
    .peak_fill   (peak_fill)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // offer one request word and hold it until the block takes it;
  // valid stays high into the next word unless a gap is drawn
  task automatic send_word(input logic [TYPE_W-1:0] kind, input logic [WORD_W-1:0] word,
                           input logic [POS_W-1:0] pos);
    req.valid     <= 1'b1;
    req.req_type  <= kind;
    req.data_word <= word;
    req.position  <= pos;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    sent++;
    if (tx_gaps && $urandom_range(0, 4) == 0) begin
      req.valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
  endtask

  // stop offering and wait until every predicted result word has come back;
  // the first edge lets the checker's count settle
  task automatic wait_drained();
    req.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // request mix per phase, weights sum to 100
  function automatic logic [TYPE_W-1:0] pick_kind(int mode);
    int w[8];
    int r;
    int acc;
    case (mode)
      MODE_FILL:  w = '{35, 30, 8, 7, 9, 9, 0, 2};
      MODE_DRAIN: w = '{8, 7, 33, 32, 9, 9, 0, 2};
      default:    w = '{18, 17, 15, 15, 14, 14, 5, 2};
    endcase
    r   = $urandom_range(0, 99);
    acc = 0;
    for (int k = 0; k < 8; k++) begin
      acc += w[k];
      if (r < acc) return k[TYPE_W-1:0];
    end
    return dedq_pkg::REQ_PUSH_BACK;
  endfunction

  // half small indexes near the count, else near the top of 16 bits or anywhere in 16 bits
  function automatic logic [POS_W-1:0] pick_pos();
    case ($urandom_range(0, 3))
      0:       return POS_W'($urandom_range(0, 65535));
      1:       return POS_W'(32'hFFFF - $urandom_range(0, 80));
      default: return POS_W'($urandom_range(0, 70));
    endcase
  endfunction

  // receiver: random stalls, plus one long hold asked for by the stimulus
  initial begin
    hold_done = 1'b0;
    rsp.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_long && !hold_done) begin
        rsp.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_done = 1'b1;
        rsp.ready <= 1'b1;
        @(posedge clk);
      end else if (rx_gaps && $urandom_range(0, 5) == 0) begin
        rsp.ready <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk);
        rsp.ready <= 1'b1;
        @(posedge clk);
      end else begin
        rsp.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // watchdog: too long with no word moving on either channel ends the run
  initial begin
    int stalled;
    stalled = 0;
    while (stalled < WATCHDOG) begin
      @(posedge clk);
      if (rst || (req.valid && req.ready) || (rsp.valid && rsp.ready)) stalled = 0;
      else stalled++;
    end
    $display("timeout: no word accepted for %0d cycles", WATCHDOG);
    $display("[bounded_double_ended_queue_core] ERROR");
    $finish;
  end

  initial begin
    int mode;
    int schedule[PHASES];
    schedule = '{MODE_FILL, MODE_FILL, MODE_DRAIN, MODE_DRAIN, MODE_MIX,
                 MODE_FILL, MODE_FILL, MODE_MIX, MODE_DRAIN, MODE_MIX};
    sent          = 0;
    tx_gaps       = 1'b0;
    rst           <= 1'b1;
    req.valid     <= 1'b0;
    req.req_type  <= dedq_pkg::REQ_PUSH_BACK;
    req.data_word <= '0;
    req.position  <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed: empty pops, access on empty inserts a zero, index extremes
    send_word(dedq_pkg::REQ_POP_BACK,   '0, '0);
    send_word(dedq_pkg::REQ_POP_FRONT,  '0, '0);
    send_word(dedq_pkg::REQ_READ,       '0, 16'hFFFF);
    send_word(dedq_pkg::REQ_CLEAR,      '0, '0);
    send_word(dedq_pkg::REQ_WRITE,      {WORD_W{1'b1}}, 16'h1234);
    send_word(dedq_pkg::REQ_READ,       '0, '0);
    send_word(dedq_pkg::REQ_PUSH_BACK,  '0, '0);
    send_word(dedq_pkg::REQ_PUSH_FRONT, {WORD_W{1'b1}}, 16'hFFFF);
    send_word(dedq_pkg::REQ_PUSH_BACK,  64'hA5A5_A5A5_A5A5_A5A5, '0);
    send_word(dedq_pkg::REQ_READ,       '0, 16'hFFFF);
    send_word(dedq_pkg::REQ_WRITE,      64'h5A5A_5A5A_5A5A_5A5A, 16'h8000);
    send_word(dedq_pkg::REQ_READ,       '0, 16'd2);
    send_word(dedq_pkg::REQ_READ,       '0, 16'd1);
    send_word(dedq_pkg::REQ_POP_FRONT,  '0, '0);
    send_word(dedq_pkg::REQ_POP_BACK,   '0, '0);
    // unused request code leaves the queue alone
    send_word(REQ_UNUSED,               {WORD_W{1'b1}}, 16'hFFFF);
    send_word(dedq_pkg::REQ_CLEAR,      '0, '0);
    send_word(dedq_pkg::REQ_READ,       '0, 16'd1);
    send_word(dedq_pkg::REQ_POP_FRONT,  '0, '0);
    send_word(dedq_pkg::REQ_POP_FRONT,  '0, '0);
    wait_drained();

    for (int ph = 0; ph < PHASES; ph++) begin
      mode = schedule[ph];
      if (ph == PHASES - 1) begin
        // last stretch runs with no idling on either side
        tx_gaps = 1'b0;
        rx_gaps <= 1'b0;
      end else if (ph == 1) begin
        // queue is well filled here: receiver holds off while the sender
        // keeps offering, so the command queue fills and req.ready drops
        tx_gaps = 1'b0;
        rx_gaps <= 1'b0;
        hold_long <= 1'b1;
      end else begin
        tx_gaps = ($urandom_range(0, 2) != 0);
        rx_gaps <= ($urandom_range(0, 2) != 0);
      end
      if (ph == 4) wait_drained();
      for (int n = 0; n < PHASE_ITEMS; n++)
        send_word(pick_kind(mode), {$urandom, $urandom}, pick_pos());
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d requests: %0d pushes refused when full, %0d pops on an empty queue,",
             sent, full_hits, empty_hits);
    $display("peak occupancy %0d of %0d, with stalls on both channels and one long hold",
             peak_fill, DEPTH);
    if (errors == 0 && pending == 0) begin
      $display("[bounded_double_ended_queue_core] OK");
    end else begin
      $display("[bounded_double_ended_queue_core] ERROR");
    end
    $finish;
  end

endmodule

### sim.f
sv/dedq_pkg.sv
sv/dedq_req_if.sv
sv/dedq_rsp_if.sv
sv/dedq_ram.sv
sv/dedq_front.sv
sv/dedq_div.sv
sv/dedq_back.sv
sv/bounded_double_ended_queue_core.sv
tb/dedq_checker.sv
tb/tb.sv
